// ===== rtl/mtep_pkg.sv =====
package mtep_pkg;

  localparam int unsigned DELTA_W      = 28;
  localparam int unsigned TEMPO_W      = 24;
  localparam int unsigned TPQ_W        = 15;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned DIVIDEND_W   = TEMPO_W + 1;
  localparam int unsigned DIV_STEPS    = DIVIDEND_W;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [TPQ_W-1:0] TPQ_RESET = 15'd96;
  localparam logic [LEN_W-1:0] LEN_RESET = 32'd0;

  localparam logic REG_TICKS_PER_QUARTER = 1'b0;
  localparam logic REG_TRACK_LENGTH      = 1'b1;

  localparam logic [7:0] STATUS_META    = 8'hFF;
  localparam logic [7:0] META_COPYRIGHT = 8'h02;
  localparam logic [7:0] META_NAME      = 8'h03;
  localparam logic [7:0] META_CH_PREFIX = 8'h20;
  localparam logic [7:0] META_END       = 8'h2F;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_TIME_SIG  = 8'h58;
  localparam logic [7:0] META_KEY_SIG   = 8'h59;
  localparam logic [7:0] META_SEQ_SPEC  = 8'h7F;
  localparam logic [7:0] PREFIX_SKIP    = 8'd2;

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_CONTROL  = 4'hB;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_BEND     = 4'hE;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_CONTROL  = 3'd2,
    KIND_PROGRAM  = 3'd3,
    KIND_BEND     = 3'd4,
    KIND_TEMPO    = 3'd5,
    KIND_END      = 3'd6,
    KIND_ERROR    = 3'd7
  } event_kind_e;

  typedef enum logic [3:0] {
    PH_DELTA_FIRST = 4'd0,
    PH_DELTA_MORE  = 4'd1,
    PH_STATUS      = 4'd2,
    PH_DATA1       = 4'd3,
    PH_DATA2       = 4'd4,
    PH_META_TYPE   = 4'd5,
    PH_META_LEN    = 4'd6,
    PH_SKIP        = 4'd7,
    PH_TEMPO_LEN   = 4'd8,
    PH_TEMPO_HI    = 4'd9,
    PH_TEMPO_MID   = 4'd10,
    PH_TEMPO_LO    = 4'd11
  } parse_phase_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } back_state_e;

  typedef struct packed {
    event_kind_e          kind;
    logic [DELTA_W-1:0]   delta;
    logic [3:0]           channel;
    logic [7:0]           data_first;
    logic [7:0]           data_second;
    logic [TEMPO_W-1:0]   tempo;
  } evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic chan_ok(input logic [7:0] status);
    logic ok;
    case (status[7:4])
      NIB_NOTE_OFF, NIB_NOTE_ON, NIB_CONTROL, NIB_PROGRAM, NIB_BEND: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic event_kind_e chan_kind(input logic [7:0] status);
    event_kind_e k;
    case (status[7:4])
      NIB_NOTE_OFF: k = KIND_NOTE_OFF;
      NIB_NOTE_ON:  k = KIND_NOTE_ON;
      NIB_CONTROL:  k = KIND_CONTROL;
      NIB_PROGRAM:  k = KIND_PROGRAM;
      NIB_BEND:     k = KIND_BEND;
      default:      k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/mtep_front.sv =====
module mtep_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [7:0]                  track_byte_i,
  input  logic [mtep_pkg::LEN_W-1:0]  track_length_i,
  output logic                        push_o,
  output mtep_pkg::evt_t              push_evt_o
);

  mtep_pkg::parse_phase_e           phase_q, phase_d;
  logic [mtep_pkg::DELTA_W-1:0]     delta_q, delta_d;
  logic [7:0]                       running_q, running_d;
  logic [7:0]                       cur_q, cur_d;
  logic [7:0]                       first_q, first_d;
  logic [7:0]                       skip_q, skip_d;
  logic [mtep_pkg::TEMPO_W-1:0]     tempo_q, tempo_d;
  logic [mtep_pkg::LEN_W-1:0]       count_q, count_d;
  logic                             stopped_q, stopped_d;

  logic                             take_data1;
  logic [7:0]                       status_sel;
  logic [7:0]                       b;

  assign b = track_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mtep_pkg::PH_DELTA_FIRST;
      delta_q   <= '0;
      running_q <= '0;
      cur_q     <= '0;
      first_q   <= '0;
      skip_q    <= '0;
      tempo_q   <= '0;
      count_q   <= '0;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      delta_q   <= delta_d;
      running_q <= running_d;
      cur_q     <= cur_d;
      first_q   <= first_d;
      skip_q    <= skip_d;
      tempo_q   <= tempo_d;
      count_q   <= count_d;
      stopped_q <= stopped_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    delta_d    = delta_q;
    running_d  = running_q;
    cur_d      = cur_q;
    first_d    = first_q;
    skip_d     = skip_q;
    tempo_d    = tempo_q;
    count_d    = count_q;
    stopped_d  = stopped_q;
    take_data1 = 1'b0;
    status_sel = cur_q;

    push_o                 = 1'b0;
    push_evt_o.kind        = mtep_pkg::KIND_ERROR;
    push_evt_o.delta       = delta_q;
    push_evt_o.channel     = '0;
    push_evt_o.data_first  = '0;
    push_evt_o.data_second = '0;
    push_evt_o.tempo       = '0;

    if (accept_i && !stopped_q) begin
      if (count_q >= track_length_i) begin
        // out of track bytes: clean end only between events
        stopped_d = 1'b1;
        push_o    = 1'b1;
        push_evt_o.kind = (phase_q == mtep_pkg::PH_DELTA_FIRST) ? mtep_pkg::KIND_END
                                                                : mtep_pkg::KIND_ERROR;
      end else begin
        count_d = count_q + 32'd1;
        case (phase_q)
          mtep_pkg::PH_DELTA_FIRST, mtep_pkg::PH_DELTA_MORE: begin
            delta_d = {delta_q[mtep_pkg::DELTA_W-8:0], b[6:0]};
            phase_d = b[7] ? mtep_pkg::PH_DELTA_MORE : mtep_pkg::PH_STATUS;
          end
          mtep_pkg::PH_STATUS: begin
            if (b == mtep_pkg::STATUS_META) begin
              phase_d = mtep_pkg::PH_META_TYPE;
            end else if (b[7]) begin
              if (!mtep_pkg::chan_ok(b)) begin
                stopped_d = 1'b1;
                push_o    = 1'b1;
              end else begin
                cur_d   = b;
                phase_d = mtep_pkg::PH_DATA1;
              end
            end else if (!mtep_pkg::chan_ok(running_q)) begin
              stopped_d = 1'b1;
              push_o    = 1'b1;
            end else begin
              // running status: this byte is already the first data byte
              cur_d      = running_q;
              status_sel = running_q;
              take_data1 = 1'b1;
            end
          end
          mtep_pkg::PH_DATA1: begin
            take_data1 = 1'b1;
          end
          mtep_pkg::PH_DATA2: begin
            push_o                 = 1'b1;
            push_evt_o.kind        = mtep_pkg::chan_kind(cur_q);
            push_evt_o.channel     = cur_q[3:0];
            push_evt_o.data_first  = first_q;
            push_evt_o.data_second = b;
            running_d              = cur_q;
            phase_d                = mtep_pkg::PH_DELTA_FIRST;
            delta_d                = '0;
          end
          mtep_pkg::PH_META_TYPE: begin
            case (b) inside
              mtep_pkg::META_COPYRIGHT, mtep_pkg::META_NAME, mtep_pkg::META_TIME_SIG,
              mtep_pkg::META_KEY_SIG, mtep_pkg::META_SEQ_SPEC: begin
                phase_d = mtep_pkg::PH_META_LEN;
              end
              mtep_pkg::META_CH_PREFIX: begin
                skip_d  = mtep_pkg::PREFIX_SKIP;
                phase_d = mtep_pkg::PH_SKIP;
              end
              mtep_pkg::META_END: begin
                stopped_d       = 1'b1;
                push_o          = 1'b1;
                push_evt_o.kind = mtep_pkg::KIND_END;
              end
              mtep_pkg::META_TEMPO: begin
                phase_d = mtep_pkg::PH_TEMPO_LEN;
              end
              default: begin
                stopped_d = 1'b1;
                push_o    = 1'b1;
              end
            endcase
          end
          mtep_pkg::PH_META_LEN: begin
            skip_d = b;
            if (b == 8'd0) begin
              phase_d = mtep_pkg::PH_DELTA_FIRST;
              delta_d = '0;
            end else begin
              phase_d = mtep_pkg::PH_SKIP;
            end
          end
          mtep_pkg::PH_SKIP: begin
            skip_d = skip_q - 8'd1;
            if (skip_q == 8'd1) begin
              phase_d = mtep_pkg::PH_DELTA_FIRST;
              delta_d = '0;
            end
          end
          mtep_pkg::PH_TEMPO_LEN: begin
            tempo_d = '0;
            phase_d = mtep_pkg::PH_TEMPO_HI;
          end
          mtep_pkg::PH_TEMPO_HI: begin
            tempo_d = {tempo_q[mtep_pkg::TEMPO_W-9:0], b};
            phase_d = mtep_pkg::PH_TEMPO_MID;
          end
          mtep_pkg::PH_TEMPO_MID: begin
            tempo_d = {tempo_q[mtep_pkg::TEMPO_W-9:0], b};
            phase_d = mtep_pkg::PH_TEMPO_LO;
          end
          mtep_pkg::PH_TEMPO_LO: begin
            tempo_d          = {tempo_q[mtep_pkg::TEMPO_W-9:0], b};
            push_o           = 1'b1;
            push_evt_o.kind  = mtep_pkg::KIND_TEMPO;
            push_evt_o.tempo = {tempo_q[mtep_pkg::TEMPO_W-9:0], b};
            phase_d          = mtep_pkg::PH_DELTA_FIRST;
            delta_d          = '0;
          end
          default: begin
            phase_d = mtep_pkg::PH_DELTA_FIRST;
            delta_d = '0;
          end
        endcase

        if (take_data1) begin
          first_d = b;
          if (mtep_pkg::chan_kind(status_sel) == mtep_pkg::KIND_PROGRAM) begin
            push_o                 = 1'b1;
            push_evt_o.kind        = mtep_pkg::KIND_PROGRAM;
            push_evt_o.channel     = status_sel[3:0];
            push_evt_o.data_first  = b;
            push_evt_o.data_second = '0;
            running_d              = status_sel;
            phase_d                = mtep_pkg::PH_DELTA_FIRST;
            delta_d                = '0;
          end else begin
            phase_d = mtep_pkg::PH_DATA2;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/mtep_queue.sv =====
module mtep_queue #(
  parameter int unsigned Depth = mtep_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  mtep_pkg::evt_t          push_evt_i,
  input  logic                    pop_i,
  output mtep_pkg::evt_t          head_o,
  output mtep_pkg::queue_status_t status_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);

  mtep_pkg::evt_t  slot_q [Depth];
  logic [AW-1:0]   wr_q, wr_d;
  logic [AW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_evt_i;
    end
  end

endmodule

// ===== rtl/mtep_back.sv =====
module mtep_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mtep_pkg::evt_t              head_i,
  input  mtep_pkg::queue_status_t     queue_i,
  output logic                        pop_o,
  input  logic [mtep_pkg::TPQ_W-1:0]  ticks_per_quarter_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mtep_pkg::evt_t              out_evt_o,
  output logic [mtep_pkg::TEMPO_W-1:0] out_upt_o
);

  localparam int unsigned NW = mtep_pkg::DIVIDEND_W;
  localparam int unsigned DW = mtep_pkg::TPQ_W;
  localparam int unsigned SW = $clog2(mtep_pkg::DIV_STEPS + 1);

  mtep_pkg::back_state_e  state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  mtep_pkg::evt_t         out_evt_q, out_evt_d;
  logic [mtep_pkg::TEMPO_W-1:0] out_upt_q, out_upt_d;
  mtep_pkg::evt_t         hold_q, hold_d;
  logic [NW-1:0]          num_q, num_d;
  logic [DW-1:0]          rem_q, rem_d;
  logic [DW-1:0]          div_q, div_d;
  logic [SW-1:0]          step_q, step_d;

  logic                   out_free;
  logic [DW-1:0]          divisor;
  logic [DW:0]            trial;
  logic [DW:0]            diff;
  logic                   ge;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_evt_o   = out_evt_q;
  assign out_upt_o   = out_upt_q;

  assign divisor = (ticks_per_quarter_i == '0) ? DW'(1) : ticks_per_quarter_i;
  assign trial   = {rem_q, num_q[NW-1]};
  assign diff    = trial - {1'b0, div_q};
  assign ge      = (trial >= {1'b0, div_q});

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_evt_d   = out_evt_q;
    out_upt_d   = out_upt_q;
    hold_d      = hold_q;
    num_d       = num_q;
    rem_d       = rem_q;
    div_d       = div_q;
    step_d      = step_q;
    pop_o       = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mtep_pkg::BK_IDLE: begin
        if (!queue_i.empty) begin
          if (head_i.kind == mtep_pkg::KIND_TEMPO) begin
            // bias by a quarter of the divisor, then divide
            pop_o   = 1'b1;
            hold_d  = head_i;
            div_d   = divisor;
            num_d   = {1'b0, head_i.tempo} + NW'(divisor >> 2);
            rem_d   = '0;
            step_d  = SW'(mtep_pkg::DIV_STEPS);
            state_d = mtep_pkg::BK_DIV;
          end else if (out_free) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            out_evt_d   = head_i;
            out_upt_d   = '0;
          end
        end
      end
      mtep_pkg::BK_DIV: begin
        if (step_q != '0) begin
          // one restoring quotient bit per cycle
          rem_d  = ge ? diff[DW-1:0] : trial[DW-1:0];
          num_d  = {num_q[NW-2:0], ge};
          step_d = step_q - SW'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_evt_d   = hold_q;
          out_upt_d   = num_q[mtep_pkg::TEMPO_W-1:0];
          state_d     = mtep_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = mtep_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtep_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_evt_q <= out_evt_d;
    out_upt_q <= out_upt_d;
    hold_q    <= hold_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
  end

endmodule

// ===== rtl/midi_track_event_parser_unit.sv =====
// Takes one track byte per cycle while the event queue has room.
// After its last byte a result passes through the event queue and then the output register;
// tempo events also go through the bit-serial divider (one quotient bit a cycle).
// Throughput: one byte per cycle; input stalls only when the queue is full,
// which happens while a tempo division or output stall holds the back end.
// Reset (async, active low) clears parser, queue and output valid; ppq -> 96, length -> 0.
module midi_track_event_parser_unit #(
  parameter int unsigned QueueDepth = mtep_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [mtep_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              track_valid_i,
  output logic                              track_stall_o,
  input  logic [7:0]                        track_byte_i,
  output logic                              event_valid_o,
  input  logic                              event_stall_i,
  output logic [2:0]                        event_kind_o,
  output logic [mtep_pkg::DELTA_W-1:0]      delta_ticks_o,
  output logic [3:0]                        channel_o,
  output logic [7:0]                        data_first_o,
  output logic [7:0]                        data_second_o,
  output logic [mtep_pkg::TEMPO_W-1:0]      tempo_us_o,
  output logic [mtep_pkg::TEMPO_W-1:0]      us_per_tick_o
);

  logic [mtep_pkg::TPQ_W-1:0]  tpq_q;
  logic [mtep_pkg::LEN_W-1:0]  len_q;

  logic                        accept;
  logic                        push;
  logic                        pop;
  mtep_pkg::evt_t              push_evt;
  mtep_pkg::evt_t              head;
  mtep_pkg::evt_t              out_evt;
  mtep_pkg::queue_status_t     qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpq_q <= mtep_pkg::TPQ_RESET;
      len_q <= mtep_pkg::LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mtep_pkg::REG_TICKS_PER_QUARTER: tpq_q <= cfg_data_i[mtep_pkg::TPQ_W-1:0];
        mtep_pkg::REG_TRACK_LENGTH:      len_q <= cfg_data_i[mtep_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign track_stall_o = qstat.full;
  assign accept        = track_valid_i && !track_stall_o;

  mtep_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .track_byte_i   (track_byte_i),
    .track_length_i (len_q),
    .push_o         (push),
    .push_evt_o     (push_evt)
  );

  mtep_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_evt_i (push_evt),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (qstat)
  );

  mtep_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .queue_i             (qstat),
    .pop_o               (pop),
    .ticks_per_quarter_i (tpq_q),
    .out_valid_o         (event_valid_o),
    .out_stall_i         (event_stall_i),
    .out_evt_o           (out_evt),
    .out_upt_o           (us_per_tick_o)
  );

  assign event_kind_o  = out_evt.kind;
  assign delta_ticks_o = out_evt.delta;
  assign channel_o     = out_evt.channel;
  assign data_first_o  = out_evt.data_first;
  assign data_second_o = out_evt.data_second;
  assign tempo_us_o    = out_evt.tempo;

endmodule

// ===== rtl/mtep_checker.sv =====
module mtep_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              event_valid_o,
  input logic                              event_stall_i,
  input logic [2:0]                        event_kind_o,
  input logic [mtep_pkg::DELTA_W-1:0]      delta_ticks_o,
  input logic [3:0]                        channel_o,
  input logic [7:0]                        data_first_o,
  input logic [7:0]                        data_second_o,
  input logic [mtep_pkg::TEMPO_W-1:0]      tempo_us_o,
  input logic [mtep_pkg::TEMPO_W-1:0]      us_per_tick_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_stall_i |=> event_valid_o && $stable(event_kind_o) &&
      $stable(delta_ticks_o) && $stable(channel_o) && $stable(data_first_o) &&
      $stable(data_second_o) && $stable(tempo_us_o) && $stable(us_per_tick_o))
    else $error("event request changed while stalled");

  a_no_tempo_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o != mtep_pkg::KIND_TEMPO |->
      tempo_us_o == '0 && us_per_tick_o == '0)
    else $error("tempo fields set on non-tempo event");

  a_program_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o == mtep_pkg::KIND_PROGRAM |-> data_second_o == 8'd0)
    else $error("program change carries a second data byte");

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o == mtep_pkg::KIND_TEMPO |-> us_per_tick_o <= tempo_us_o)
    else $error("microseconds per tick exceed tempo");

endmodule

bind midi_track_event_parser_unit mtep_checker u_checker (.*);

// ===== test/testbench.sv =====
module testbench;
  import mtep_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_BYTES  = 340;

  typedef struct packed {
    event_kind_e         kind;
    logic [DELTA_W-1:0]  delta;
    logic [3:0]          channel;
    logic [7:0]          data_first;
    logic [7:0]          data_second;
    logic [TEMPO_W-1:0]  tempo;
    logic [TEMPO_W-1:0]  tick_us;
  } midi_event_t;

  // Byte-serial track decoder plus the queue of events it says must come out.
  class track_scoreboard;
    midi_event_t        pending_events[$];
    logic [TPQ_W-1:0]   tpq = TPQ_RESET;
    logic [LEN_W-1:0]   track_len = LEN_RESET;
    parse_phase_e       phase = PH_DELTA_FIRST;
    logic [DELTA_W-1:0] delta_acc = '0;
    logic [7:0]         run_status = '0;
    logic [7:0]         cur_status = '0;
    logic [7:0]         first_byte = '0;
    logic [7:0]         skip_left = '0;
    logic [TEMPO_W-1:0] tempo_acc = '0;
    logic [LEN_W-1:0]   consumed = '0;
    bit                 halted = 1'b0;
    int                 errors = 0;
    int                 matched = 0;

    function void set_register(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_TICKS_PER_QUARTER) tpq = value[TPQ_W-1:0];
      else track_len = value;
    endfunction

    function bit status_kind(logic [7:0] status, output event_kind_e kind);
      kind = KIND_ERROR;
      case (status[7:4])
        NIB_NOTE_OFF: kind = KIND_NOTE_OFF;
        NIB_NOTE_ON:  kind = KIND_NOTE_ON;
        NIB_CONTROL:  kind = KIND_CONTROL;
        NIB_PROGRAM:  kind = KIND_PROGRAM;
        NIB_BEND:     kind = KIND_BEND;
        default:      return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void push(event_kind_e kind, logic [3:0] ch, logic [7:0] d1, logic [7:0] d2,
                       logic [TEMPO_W-1:0] tempo, logic [TEMPO_W-1:0] tick_us);
      pending_events.push_back('{kind, delta_acc, ch, d1, d2, tempo, tick_us});
    endfunction

    function void halt_with(event_kind_e kind);
      halted = 1'b1;
      push(kind, '0, '0, '0, '0, '0);
    endfunction

    function void next_event();
      phase = PH_DELTA_FIRST;
      delta_acc = '0;
    endfunction

    function void emit_channel(logic [7:0] d2);
      event_kind_e kind;
      void'(status_kind(cur_status, kind));
      push(kind, cur_status[3:0], first_byte, d2, '0, '0);
      run_status = cur_status;
      next_event();
    endfunction

    function void take_first(logic [7:0] b);
      event_kind_e kind;
      first_byte = b;
      void'(status_kind(cur_status, kind));
      if (kind == KIND_PROGRAM) emit_channel(8'h00);
      else phase = PH_DATA2;
    endfunction

    function void take_byte(logic [7:0] b);
      event_kind_e kind;
      logic [31:0] divisor;
      if (halted) return;
      if (consumed >= track_len) begin
        halt_with(phase == PH_DELTA_FIRST ? KIND_END : KIND_ERROR);
        return;
      end
      consumed++;
      case (phase)
        PH_DELTA_FIRST, PH_DELTA_MORE: begin
          delta_acc = {delta_acc[DELTA_W-8:0], b[6:0]};
          phase = b[7] ? PH_DELTA_MORE : PH_STATUS;
        end
        PH_STATUS: begin
          if (b == STATUS_META) begin
            phase = PH_META_TYPE;
          end else if (b[7]) begin
            if (!status_kind(b, kind)) begin
              halt_with(KIND_ERROR);
            end else begin
              cur_status = b;
              phase = PH_DATA1;
            end
          end else if (!status_kind(run_status, kind)) begin
            halt_with(KIND_ERROR);
          end else begin
            // running status: this byte is already the first data byte
            cur_status = run_status;
            take_first(b);
          end
        end
        PH_DATA1: take_first(b);
        PH_DATA2: emit_channel(b);
        PH_META_TYPE: begin
          case (b)
            META_COPYRIGHT, META_NAME, META_TIME_SIG, META_KEY_SIG, META_SEQ_SPEC:
              phase = PH_META_LEN;
            META_CH_PREFIX: begin
              skip_left = PREFIX_SKIP;
              phase = PH_SKIP;
            end
            META_END:   halt_with(KIND_END);
            META_TEMPO: phase = PH_TEMPO_LEN;
            default:    halt_with(KIND_ERROR);
          endcase
        end
        PH_META_LEN: begin
          skip_left = b;
          if (b == 8'h00) next_event();
          else phase = PH_SKIP;
        end
        PH_SKIP: begin
          skip_left--;
          if (skip_left == 8'h00) next_event();
        end
        PH_TEMPO_LEN: begin
          tempo_acc = '0;
          phase = PH_TEMPO_HI;
        end
        PH_TEMPO_HI: begin
          tempo_acc = {tempo_acc[TEMPO_W-9:0], b};
          phase = PH_TEMPO_MID;
        end
        PH_TEMPO_MID: begin
          tempo_acc = {tempo_acc[TEMPO_W-9:0], b};
          phase = PH_TEMPO_LO;
        end
        PH_TEMPO_LO: begin
          tempo_acc = {tempo_acc[TEMPO_W-9:0], b};
          divisor = (tpq == '0) ? 32'd1 : 32'(tpq);
          push(KIND_TEMPO, '0, '0, '0, tempo_acc,
               TEMPO_W'((32'(tempo_acc) + (divisor >> 2)) / divisor));
          next_event();
        end
        default: next_event();
      endcase
    endfunction

    function void check_event(logic [2:0] kind, logic [DELTA_W-1:0] delta, logic [3:0] ch,
                              logic [7:0] d1, logic [7:0] d2, logic [TEMPO_W-1:0] tempo,
                              logic [TEMPO_W-1:0] tick_us);
      midi_event_t want;
      int          bad;
      if (pending_events.size() == 0) begin
        $error("event with none pending: kind %0d delta %0d", kind, delta);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      bad = errors;
      if (want.kind !== kind) begin
        $error("event_kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (want.delta !== delta) begin
        $error("delta_ticks: expected %0d, got %0d", want.delta, delta);
        errors++;
      end
      if (want.channel !== ch) begin
        $error("channel: expected %0d, got %0d", want.channel, ch);
        errors++;
      end
      if (want.data_first !== d1) begin
        $error("data_first: expected %0d, got %0d", want.data_first, d1);
        errors++;
      end
      if (want.data_second !== d2) begin
        $error("data_second: expected %0d, got %0d", want.data_second, d2);
        errors++;
      end
      if (want.tempo !== tempo) begin
        $error("tempo_us: expected %0d, got %0d", want.tempo, tempo);
        errors++;
      end
      if (want.tick_us !== tick_us) begin
        $error("us_per_tick: expected %0d, got %0d", want.tick_us, tick_us);
        errors++;
      end
      if (bad == errors) matched++;
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_index_i = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  track_valid_i = 1'b0;
  logic                  track_stall_o;
  logic [7:0]            track_byte_i = '0;
  logic                  event_valid_o;
  logic                  event_stall_i = 1'b0;
  logic [2:0]            event_kind_o;
  logic [DELTA_W-1:0]    delta_ticks_o;
  logic [3:0]            channel_o;
  logic [7:0]            data_first_o;
  logic [7:0]            data_second_o;
  logic [TEMPO_W-1:0]    tempo_us_o;
  logic [TEMPO_W-1:0]    us_per_tick_o;

  track_scoreboard sb = new;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  midi_track_event_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .track_valid_i (track_valid_i),
    .track_stall_o (track_stall_o),
    .track_byte_i  (track_byte_i),
    .event_valid_o (event_valid_o),
    .event_stall_i (event_stall_i),
    .event_kind_o  (event_kind_o),
    .delta_ticks_o (delta_ticks_o),
    .channel_o     (channel_o),
    .data_first_o  (data_first_o),
    .data_second_o (data_second_o),
    .tempo_us_o    (tempo_us_o),
    .us_per_tick_o (us_per_tick_o)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) event_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && event_valid_o && !event_stall_i)
      sb.check_event(event_kind_o, delta_ticks_o, channel_o, data_first_o, data_second_o,
                     tempo_us_o, us_per_tick_o);
  end

  always @(posedge clk_i) begin
    if ((track_valid_i && !track_stall_o) || (event_valid_o && !event_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: no progress for %0d cycles", STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      track_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    track_valid_i <= 1'b1;
    track_byte_i <= b;
    do @(posedge clk_i); while (track_stall_o);
    sb.take_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, value);
    @(negedge clk_i);
  endtask

  // Hold the track side until every event is out and the divider has settled.
  task automatic drain();
    track_valid_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_data();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255, 128));
    return 8'($urandom_range(127));
  endfunction

  task automatic send_delta(input int nbytes);
    for (int i = 0; i < nbytes - 1; i++) send_byte({1'b1, 7'($urandom)});
    send_byte({1'b0, 7'($urandom)});
  endtask

  task automatic send_tempo(input logic [TEMPO_W-1:0] tempo);
    send_byte(STATUS_META);
    send_byte(META_TEMPO);
    send_byte(8'($urandom));
    send_byte(tempo[23:16]);
    send_byte(tempo[15:8]);
    send_byte(tempo[7:0]);
  endtask

  task automatic random_event();
    int          pick;
    int          len;
    logic [3:0]  nib;
    logic        running;
    logic [7:0]  meta_kind;
    pick = $urandom_range(99);
    if (pick < 40) send_delta(1);
    else if (pick < 70) send_delta(2);
    else if (pick < 85) send_delta(3);
    else if (pick < 95) send_delta(4);
    else send_delta($urandom_range(6, 5));

    pick = $urandom_range(99);
    if (pick < 60) begin
      case ($urandom_range(4))
        0: nib = NIB_NOTE_OFF;
        1: nib = NIB_NOTE_ON;
        2: nib = NIB_CONTROL;
        3: nib = NIB_PROGRAM;
        default: nib = NIB_BEND;
      endcase
      running = (sb.run_status != 8'h00) && ($urandom_range(1) == 1);
      if (running) begin
        nib = sb.run_status[7:4];
        send_byte(8'($urandom_range(127)));
      end else begin
        send_byte({nib, 4'($urandom)});
        send_byte(rand_data());
      end
      if (nib != NIB_PROGRAM) send_byte(rand_data());
    end else if (pick < 75) begin
      case ($urandom_range(4))
        0: meta_kind = META_COPYRIGHT;
        1: meta_kind = META_NAME;
        2: meta_kind = META_TIME_SIG;
        3: meta_kind = META_KEY_SIG;
        default: meta_kind = META_SEQ_SPEC;
      endcase
      len = ($urandom_range(49) == 0) ? 255 : $urandom_range(6);
      send_byte(STATUS_META);
      send_byte(meta_kind);
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom));
    end else if (pick < 85) begin
      send_byte(STATUS_META);
      send_byte(META_CH_PREFIX);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end else begin
      case ($urandom_range(5))
        0: send_tempo('0);
        1: send_tempo('1);
        2: send_tempo(TEMPO_W'($urandom_range(1000)));
        default: send_tempo(TEMPO_W'($urandom));
      endcase
    end
  endtask

  logic [7:0] intro_bytes[$] = '{
    8'h00, 8'h90, 8'h3C, 8'h64,                      // note on
    8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h8F, 8'hFF, 8'h80, // widest delta, note off, high data
    8'h00, 8'hB5, 8'h00, 8'h7F,                      // control
    8'h00, 8'hC3, 8'h7F,                             // program
    8'h81, 8'h80, 8'h80, 8'h80, 8'h01,               // five-byte delta
    8'hE0, 8'h00, 8'h40,                             // bend
    8'h00, 8'h7F, 8'h00,                             // bend by running status
    8'h00, 8'hFF, 8'h03, 8'h00,                      // empty track name
    8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF  // slowest tempo
  };

  initial begin
    int         target;
    int         stop_case;
    logic [7:0] junk;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_reg(REG_TRACK_LENGTH, '1);
    foreach (intro_bytes[i]) send_byte(intro_bytes[i]);

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      case (p)
        1: write_reg(REG_TICKS_PER_QUARTER, 32'd1);
        2: begin
          write_reg(REG_TICKS_PER_QUARTER, 32'd32767);
          write_reg(REG_TRACK_LENGTH, $urandom_range(32'hFFFF_FFFE, bytes_sent + 100000));
        end
        3: write_reg(REG_TICKS_PER_QUARTER, 32'd0);
        4: write_reg(REG_TICKS_PER_QUARTER, 32'($urandom_range(32767, 1)));
        default: ;
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) random_event();
    end

    // One way to stop the track; the parser stays halted afterwards.
    drain();
    idle_pct = 32;
    stall_pct = 32;
    stop_case = $urandom_range(5);
    case (stop_case)
      0: begin
        send_delta(1);
        send_byte(STATUS_META);
        send_byte(META_END);
      end
      1: begin
        do junk = 8'($urandom);
        while (junk == META_COPYRIGHT || junk == META_NAME || junk == META_CH_PREFIX ||
               junk == META_END || junk == META_TEMPO || junk == META_TIME_SIG ||
               junk == META_KEY_SIG || junk == META_SEQ_SPEC);
        send_delta(2);
        send_byte(STATUS_META);
        send_byte(junk);
      end
      2: begin
        case ($urandom_range(2))
          0: junk = {4'hA, 4'($urandom)};
          1: junk = {4'hD, 4'($urandom)};
          default: junk = 8'($urandom_range(8'hFE, 8'hF0));
        endcase
        send_delta(3);
        send_byte(junk);
      end
      3: write_reg(REG_TRACK_LENGTH, sb.consumed);
      4: begin
        write_reg(REG_TRACK_LENGTH, sb.consumed + $urandom_range(3, 1));
        send_byte(8'h00);
        send_tempo(TEMPO_W'($urandom));
      end
      default: write_reg(REG_TRACK_LENGTH, '0);
    endcase
    repeat (16) send_byte(8'($urandom));
    drain();

    $display("testbench: %0d track bytes in five pacing phases, %0d events matched",
             bytes_sent, sb.matched);
    $display("testbench: track closed by stop case %0d, trailing bytes ignored", stop_case);
    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
